FILE: sv/vde_pkg.sv
`default_nettype none
package vde_pkg;

	// one-hot mode register encoding
	typedef enum logic [5:0] {
		MODE_STARTUP = 6'b000001,
		MODE_LV      = 6'b000010,
		MODE_PRE     = 6'b000100,
		MODE_HV      = 6'b001000,
		MODE_DRIVE   = 6'b010000,
		MODE_FAULT   = 6'b100000
	} mode_t;

	// external mode numbering on the result channel
	localparam logic [2:0] MODE_NUM_STARTUP = 3'd0;
	localparam logic [2:0] MODE_NUM_LV      = 3'd1;
	localparam logic [2:0] MODE_NUM_PRE     = 3'd2;
	localparam logic [2:0] MODE_NUM_HV      = 3'd3;
	localparam logic [2:0] MODE_NUM_DRIVE   = 3'd4;
	localparam logic [2:0] MODE_NUM_FAULT   = 3'd5;

	localparam logic [3:0] FLT_NONE     = 4'd0;
	localparam logic [3:0] FLT_SHUTDOWN = 4'd1;
	localparam logic [3:0] FLT_BSPD     = 4'd2;
	localparam logic [3:0] FLT_DRIVE_LV = 4'd3;
	localparam logic [3:0] FLT_UNCAL    = 4'd4;
	localparam logic [3:0] FLT_BRAKE_NP = 4'd5;
	localparam logic [3:0] FLT_HV_OFF   = 4'd6;
	localparam logic [3:0] FLT_IMPLAUS  = 4'd7;
	localparam logic [3:0] FLT_DISCREP  = 4'd8;
	localparam logic [3:0] FLT_TIMER    = 4'd9;

	localparam logic [7:0] LOOP_MASK = 8'b00111000;
	localparam logic [2:0] SW_TC     = 3'b100;
	localparam logic [2:0] SW_HV     = 3'b010;
	localparam logic [2:0] SW_DR     = 3'b001;

	localparam logic       ACT_EVAL = 1'b0;
	localparam logic       ACT_TICK = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [1:0] REG_TICK      = 2'd2;

	localparam logic [15:0] THRESHOLD_RST = 16'd0;
	localparam logic [15:0] TIMEOUT_RST   = 16'd5000;
	localparam logic [7:0]  TICK_RST      = 8'd20;
	localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [15:0] threshold;
		logic [15:0] timeout_ms;
		logic [7:0]  tick_ms;
	} cfg_t;

	typedef struct packed {
		logic        action;
		logic [2:0]  switches;
		logic [7:0]  sdc_status;
		logic [7:0]  estop_status;
		logic        bspd_ok;
		logic [15:0] bus_voltage;
		logic        inverter_lockout;
		logic        brake_pressed;
		logic        brake_bad;
		logic        calibrated;
		logic        discrepancy_fault;
	} item_t;

	typedef struct packed {
		mode_t       mode;
		logic [3:0]  fault;
		logic [15:0] elapsed;
	} state_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] fault_code;
		logic       send_torque;
		logic       send_mc_disable;
		logic       do_calibration;
		logic       run_traction;
		logic       clear_discrepancy_timer;
	} result_t;

	function automatic logic [2:0] mode_num(input mode_t m);
		logic [2:0] n;
		case (m)
			MODE_STARTUP: n = MODE_NUM_STARTUP;
			MODE_LV:      n = MODE_NUM_LV;
			MODE_PRE:     n = MODE_NUM_PRE;
			MODE_HV:      n = MODE_NUM_HV;
			MODE_DRIVE:   n = MODE_NUM_DRIVE;
			MODE_FAULT:   n = MODE_NUM_FAULT;
			default:      n = MODE_NUM_STARTUP;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: sv/vde_cfg.sv
`default_nettype none
module vde_cfg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [15:0]      cfg_wdata,
	output vde_pkg::cfg_t         cfg
);
	import vde_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= THRESHOLD_RST;
			cfg_q.timeout_ms <= TIMEOUT_RST;
			cfg_q.tick_ms    <= TICK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold  <= cfg_wdata;
				REG_TIMEOUT:   cfg_q.timeout_ms <= cfg_wdata;
				REG_TICK:      cfg_q.tick_ms    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: sv/vde_rules.sv
`default_nettype none
module vde_rules (
	input  vde_pkg::item_t   item,
	input  vde_pkg::state_t  cur,
	input  vde_pkg::cfg_t    cfg,
	output vde_pkg::state_t  nxt,
	output vde_pkg::result_t res
);
	import vde_pkg::*;

	logic        hv, dr, closed;
	logic [16:0] sum;
	logic [15:0] el;
	mode_t       m;
	logic [3:0]  f;
	logic        torque, mcdis, calib, tc, clr;

	assign hv     = (item.switches & SW_HV) != 3'b000;
	assign dr     = (item.switches & SW_DR) != 3'b000;
	assign closed = (item.estop_status == 8'd0)
		&& ((item.sdc_status & LOOP_MASK) == LOOP_MASK);
	assign sum    = {1'b0, cur.elapsed} + {9'd0, cfg.tick_ms};

	always_comb begin
		m      = cur.mode;
		f      = cur.fault;
		el     = cur.elapsed;
		torque = 1'b0;
		mcdis  = 1'b0;
		calib  = 1'b0;
		tc     = 1'b0;
		clr    = 1'b0;
		if (item.action == ACT_TICK) begin
			if (cur.mode == MODE_PRE) begin
				el = sum[16] ? ELAPSED_MAX : sum[15:0];
				if (el > cfg.timeout_ms) begin
					m = MODE_FAULT;
					f = FLT_TIMER;
				end
			end else begin
				el = 16'd0;
			end
		end else begin
			// global faults first, later ones overwrite the code
			if (item.discrepancy_fault) begin
				m = MODE_FAULT;
				f = FLT_DISCREP;
			end
			torque = !item.inverter_lockout;
			tc     = (item.switches & SW_TC) != 3'b000;
			if (!closed) begin
				m = MODE_FAULT;
				f = FLT_SHUTDOWN;
			end
			if (!item.bspd_ok) begin
				m = MODE_FAULT;
				f = FLT_BSPD;
			end
			case (m)
				MODE_STARTUP: begin
					calib = 1'b1;
					if (!hv && !dr) m = MODE_LV;
				end
				MODE_LV: begin
					calib = 1'b1;
					if (dr) begin
						m = MODE_FAULT;
						f = FLT_DRIVE_LV;
					end else if (hv) begin
						if (item.calibrated) m = MODE_PRE;
						else begin
							m = MODE_FAULT;
							f = FLT_UNCAL;
						end
					end
				end
				MODE_PRE: begin
					if (item.bus_voltage > cfg.threshold) m = MODE_HV;
					else if (!hv) m = MODE_LV;
					else if (dr) begin
						m = MODE_FAULT;
						f = FLT_DRIVE_LV;
					end
				end
				MODE_HV: begin
					if (!hv) m = MODE_LV;
					else if (dr) begin
						if (item.brake_pressed) m = MODE_DRIVE;
						else begin
							m = MODE_FAULT;
							f = FLT_BRAKE_NP;
						end
					end
				end
				MODE_DRIVE: begin
					mcdis = item.inverter_lockout;
					if (!dr) m = MODE_HV;
					else if (!hv) begin
						m = MODE_FAULT;
						f = FLT_HV_OFF;
					end else if (item.brake_bad) begin
						m = MODE_FAULT;
						f = FLT_IMPLAUS;
					end
				end
				MODE_FAULT: begin
					if (f == FLT_BRAKE_NP) begin
						if (!hv) m = MODE_LV;
						if (!dr) m = MODE_HV;
					end else if (f == FLT_DISCREP) begin
						if (!dr) begin
							clr = 1'b1;
							m   = MODE_HV;
						end
						if (!hv) begin
							m = MODE_FAULT;
							f = FLT_HV_OFF;
						end
					end else if (f == FLT_IMPLAUS) begin
						if (!item.brake_bad && hv && dr) m = MODE_DRIVE;
						if (!hv && !dr) m = MODE_LV;
						if (!dr) m = MODE_HV;
						if (!hv) begin
							m = MODE_FAULT;
							f = FLT_HV_OFF;
						end
					end else if (f == FLT_SHUTDOWN) begin
						if (closed) m = MODE_LV;
					end else begin
						if (f == FLT_BSPD && item.bspd_ok) m = MODE_LV;
						if (!hv && !dr) m = MODE_LV;
					end
				end
				default: ;
			endcase
		end
	end

	assign nxt.mode                    = m;
	assign nxt.fault                   = f;
	assign nxt.elapsed                 = el;
	assign res.mode                    = mode_num(m);
	assign res.fault_code              = f;
	assign res.send_torque             = torque;
	assign res.send_mc_disable         = mcdis;
	assign res.do_calibration          = calib;
	assign res.run_traction            = tc;
	assign res.clear_discrepancy_timer = clr;

endmodule
`default_nettype wire

FILE: sv/vehicle_drive_enable_fsm.sv
`default_nettype none
// Drive-enable safety mode machine. Every transaction on the input channel
// (an evaluate pass or a timer tick) gives exactly one transaction on the
// result channel via the item and output registers. One transaction is
// taken per clock unless the result side stalls: the item is registered,
// the mode rules run as one combinational pass over the mode, fault and
// precharge-timer registers, and the result lands in an output register
// while those state registers update at the same edge, so the next item
// already sees the new mode. Configuration (threshold, timeout, tick
// period) may be written only while no transaction is in flight.
module vehicle_drive_enable_fsm (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [2:0]  switches,
	input  wire logic [7:0]  sdc_status,
	input  wire logic [7:0]  estop_status,
	input  wire logic        bspd_ok,
	input  wire logic [15:0] bus_voltage,
	input  wire logic        inverter_lockout,
	input  wire logic        brake_pressed,
	input  wire logic        brake_bad,
	input  wire logic        calibrated,
	input  wire logic        discrepancy_fault,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       mode,
	output logic [3:0]       fault_code,
	output logic             send_torque,
	output logic             send_mc_disable,
	output logic             do_calibration,
	output logic             run_traction,
	output logic             clear_discrepancy_timer
);
	import vde_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	state_t  state_q;
	state_t  nxt;
	result_t res;
	logic    adv_s2;
	logic    fire;

	vde_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	vde_rules u_rules (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (nxt),
		.res  (res)
	);

	assign adv_s2   = !valid_s2 || out_ready;
	assign fire     = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{action, switches, sdc_status, estop_status, bspd_ok,
				bus_voltage, inverter_lockout, brake_pressed, brake_bad, calibrated,
				discrepancy_fault};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2        <= 1'b0;
			state_q.mode    <= MODE_STARTUP;
			state_q.fault   <= FLT_NONE;
			state_q.elapsed <= 16'd0;
		end else begin
			if (adv_s2) valid_s2 <= valid_s1;
			if (fire) state_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) res_s2 <= res;
	end

	assign out_valid               = valid_s2;
	assign mode                    = res_s2.mode;
	assign fault_code              = res_s2.fault_code;
	assign send_torque             = res_s2.send_torque;
	assign send_mc_disable         = res_s2.send_mc_disable;
	assign do_calibration          = res_s2.do_calibration;
	assign run_traction            = res_s2.run_traction;
	assign clear_discrepancy_timer = res_s2.clear_discrepancy_timer;

	// a tick outside precharging always clears the timer
	a_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.action == ACT_TICK && state_q.mode != MODE_PRE
		|=> state_q.elapsed == 16'd0)
		else $error("precharge timer not cleared by tick");

	// startup is left before any fault can be recorded
	a_startup_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_STARTUP |-> state_q.fault == FLT_NONE)
		else $error("fault code set while in startup");

	// the disable message only goes out with lockout, so torque is off
	a_mcdis_torque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_mc_disable |-> !send_torque)
		else $error("disable and torque both requested");

	// an empty output register never blocks the input side
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty output register");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import vde_pkg::*;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t want;
	} step_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_THRESHOLD;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = ACT_EVAL;
	logic [2:0]  switches = '0;
	logic [7:0]  sdc_status = '0;
	logic [7:0]  estop_status = '0;
	logic        bspd_ok = 1'b0;
	logic [15:0] bus_voltage = '0;
	logic        inverter_lockout = 1'b0;
	logic        brake_pressed = 1'b0;
	logic        brake_bad = 1'b0;
	logic        calibrated = 1'b0;
	logic        discrepancy_fault = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  mode;
	logic [3:0]  fault_code;
	logic        send_torque;
	logic        send_mc_disable;
	logic        do_calibration;
	logic        run_traction;
	logic        clear_discrepancy_timer;

	vehicle_drive_enable_fsm dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predicted machine state and register copies
	logic [2:0]  pm_mode = MODE_NUM_STARTUP;
	logic [3:0]  pm_fault = FLT_NONE;
	logic [15:0] pm_elapsed = '0;
	logic [15:0] cfg_threshold = THRESHOLD_RST;
	logic [15:0] cfg_timeout = TIMEOUT_RST;
	logic [7:0]  cfg_tick = TICK_RST;

	result_t pending_results[$];
	result_t mon_got, mon_want;
	int n_sent = 0;
	int n_checked = 0;
	int n_fail = 0;
	int burst_left = 0;
	int n_settings = 1;
	step_row_t plan[25];

	function automatic void enter_fault(logic [3:0] code);
		pm_mode = MODE_NUM_FAULT;
		pm_fault = code;
	endfunction

	function automatic result_t drive_enable_step(item_t it);
		result_t r;
		logic hv, dr, closed;
		logic [16:0] sum;
		r = '0;
		hv = (it.switches & SW_HV) != 3'b000;
		dr = (it.switches & SW_DR) != 3'b000;
		closed = it.estop_status == 8'h00 && (it.sdc_status & LOOP_MASK) == LOOP_MASK;
		if (it.action == ACT_TICK) begin
			if (pm_mode == MODE_NUM_PRE) begin
				sum = {1'b0, pm_elapsed} + {9'd0, cfg_tick};
				pm_elapsed = sum[16] ? ELAPSED_MAX : sum[15:0];
				if (pm_elapsed > cfg_timeout)
					enter_fault(FLT_TIMER);
			end else begin
				pm_elapsed = '0;
			end
		end else begin
			if (it.discrepancy_fault)
				enter_fault(FLT_DISCREP);
			r.send_torque = !it.inverter_lockout;
			r.run_traction = (it.switches & SW_TC) != 3'b000;
			if (!closed)
				enter_fault(FLT_SHUTDOWN);
			if (!it.bspd_ok)
				enter_fault(FLT_BSPD);
			case (pm_mode)
				MODE_NUM_STARTUP: begin
					r.do_calibration = 1'b1;
					if (!hv && !dr)
						pm_mode = MODE_NUM_LV;
				end
				MODE_NUM_LV: begin
					r.do_calibration = 1'b1;
					if (dr)
						enter_fault(FLT_DRIVE_LV);
					else if (hv) begin
						if (it.calibrated)
							pm_mode = MODE_NUM_PRE;
						else
							enter_fault(FLT_UNCAL);
					end
				end
				MODE_NUM_PRE: begin
					if (it.bus_voltage > cfg_threshold)
						pm_mode = MODE_NUM_HV;
					else if (!hv)
						pm_mode = MODE_NUM_LV;
					else if (dr)
						enter_fault(FLT_DRIVE_LV);
				end
				MODE_NUM_HV: begin
					if (!hv)
						pm_mode = MODE_NUM_LV;
					else if (dr) begin
						if (it.brake_pressed)
							pm_mode = MODE_NUM_DRIVE;
						else
							enter_fault(FLT_BRAKE_NP);
					end
				end
				MODE_NUM_DRIVE: begin
					r.send_mc_disable = it.inverter_lockout;
					if (!dr)
						pm_mode = MODE_NUM_HV;
					else if (!hv)
						enter_fault(FLT_HV_OFF);
					else if (it.brake_bad)
						enter_fault(FLT_IMPLAUS);
				end
				MODE_NUM_FAULT: begin
					case (pm_fault)
						FLT_BRAKE_NP: begin
							if (!hv)
								pm_mode = MODE_NUM_LV;
							if (!dr)
								pm_mode = MODE_NUM_HV;
						end
						FLT_DISCREP: begin
							if (!dr) begin
								r.clear_discrepancy_timer = 1'b1;
								pm_mode = MODE_NUM_HV;
							end
							if (!hv)
								enter_fault(FLT_HV_OFF);
						end
						FLT_IMPLAUS: begin
							if (!it.brake_bad && hv && dr)
								pm_mode = MODE_NUM_DRIVE;
							if (!hv && !dr)
								pm_mode = MODE_NUM_LV;
							if (!dr)
								pm_mode = MODE_NUM_HV;
							if (!hv)
								enter_fault(FLT_HV_OFF);
						end
						FLT_SHUTDOWN: begin
							if (closed)
								pm_mode = MODE_NUM_LV;
						end
						default: begin
							if (pm_fault == FLT_BSPD && it.bspd_ok)
								pm_mode = MODE_NUM_LV;
							if (!hv && !dr)
								pm_mode = MODE_NUM_LV;
						end
					endcase
				end
				default: ;
			endcase
		end
		r.mode = pm_mode;
		r.fault_code = pm_fault;
		return r;
	endfunction

	// healthy evaluate pass: loop closed, no estop, bspd ok, no discrepancy
	function automatic item_t evl(logic [2:0] sw, logic [15:0] cap, logic lock,
			logic brake, logic bad, logic cal);
		return {ACT_EVAL, sw, LOOP_MASK, 8'h00, 1'b1, cap, lock, brake, bad, cal, 1'b0};
	endfunction

	function automatic result_t mk_res(logic [2:0] m, logic [3:0] f, logic tq, logic dis,
			logic cal, logic tc, logic clr);
		return {m, f, tq, dis, cal, tc, clr};
	endfunction

	// mostly well-formed passes steered by the predicted mode, some noise
	function automatic item_t next_item();
		item_t it;
		logic [63:0] raw;
		int pick;
		raw = {$urandom, $urandom};
		it = raw[41:0];
		if ($urandom_range(0, 99) < 8)
			return it;
		it.action = ACT_EVAL;
		it.sdc_status = it.sdc_status | LOOP_MASK;
		it.estop_status = 8'h00;
		it.bspd_ok = 1'b1;
		it.discrepancy_fault = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			it.discrepancy_fault = 1'b1;
		else if (pick < 5)
			it.sdc_status = it.sdc_status & ~(8'h08 << $urandom_range(0, 2));
		else if (pick < 7)
			it.estop_status = 8'($urandom_range(1, 255));
		else if (pick < 10)
			it.bspd_ok = 1'b0;
		it.calibrated = $urandom_range(0, 9) != 0;
		it.brake_pressed = $urandom_range(0, 5) != 0;
		it.brake_bad = $urandom_range(0, 9) == 0;
		pick = $urandom_range(0, 99);
		case (pm_mode)
			MODE_NUM_STARTUP: it.switches = pick < 80 ? 3'b000 : 3'($urandom);
			MODE_NUM_LV:      it.switches = pick < 80 ? SW_HV : 3'($urandom);
			MODE_NUM_PRE:     it.switches = pick < 85 ? SW_HV : 3'($urandom);
			MODE_NUM_HV:
				it.switches = pick < 70 ? (SW_HV | SW_DR) : pick < 85 ? SW_HV : 3'($urandom);
			MODE_NUM_DRIVE:   it.switches = pick < 80 ? (SW_HV | SW_DR) : 3'($urandom);
			default:          it.switches = 3'($urandom);
		endcase
		it.switches[2] = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 2) == 0)
			it.bus_voltage = 16'($urandom_range(cfg_threshold, 16'hFFFF));
		else
			it.bus_voltage = 16'($urandom_range(0, cfg_threshold));
		if ($urandom_range(0, 99) < (pm_mode == MODE_NUM_PRE ? 30 : 5))
			it.action = ACT_TICK;
		return it;
	endfunction

	task automatic send(input item_t it, input bit typed, input result_t want);
		int gap;
		result_t exp_res;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		{action, switches, sdc_status, estop_status, bspd_ok, bus_voltage, inverter_lockout,
			brake_pressed, brake_bad, calibrated, discrepancy_fault} <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		exp_res = drive_enable_step(it);
		if (typed)
			exp_res = want;
		pending_results.push_back(exp_res);
		n_sent++;
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_THRESHOLD: cfg_threshold = data;
			REG_TIMEOUT:   cfg_timeout = data;
			REG_TICK:      cfg_tick = data[7:0];
			default: ;
		endcase
	endtask

	task automatic run_phase(input logic [15:0] thr, input logic [15:0] tmo,
			input logic [7:0] tk, input int soak_max, input int count);
		int start;
		int n;
		item_t it;
		drain();
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_TIMEOUT, tmo);
		// upper bits of the tick write are don't-care
		write_reg(REG_TICK, {8'($urandom), tk});
		@(negedge clk) cfg_we <= 1'b0;
		n_settings++;
		start = n_sent;
		while (n_sent - start < count) begin
			if (pm_mode == MODE_NUM_PRE && $urandom_range(0, 99) < 10) begin
				// run of ticks to push the precharge timer toward timeout
				n = $urandom_range(1, soak_max);
				if (n > count - (n_sent - start))
					n = count - (n_sent - start);
				repeat (n) begin
					it = next_item();
					it.action = ACT_TICK;
					send(it, 1'b0, '0);
				end
			end else begin
				send(next_item(), 1'b0, '0);
			end
		end
	endtask

	always @(negedge clk) begin : stall_gen
		static logic [15:0] pat = 16'hFFFF;
		static int age = 0;
		if (age == 0) begin
			pat = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom);
			age = $urandom_range(16, 96);
		end
		age--;
		pat = {pat[0], pat[15:1]};
		out_ready <= pat[0];
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			mon_got = {mode, fault_code, send_torque, send_mc_disable, do_calibration,
				run_traction, clear_discrepancy_timer};
			n_checked++;
			if (pending_results.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected result transaction: mode %0d fault %0d",
						mon_got.mode, mon_got.fault_code);
			end else begin
				mon_want = pending_results.pop_front();
				if (mon_got !== mon_want) begin
					n_fail++;
					if (n_fail <= 10)
						$display({"result %0d: expected mode %0d fault %0d tq %b dis %b ",
							"cal %b tc %b clr %b, got mode %0d fault %0d tq %b dis %b ",
							"cal %b tc %b clr %b"}, n_checked,
							mon_want.mode, mon_want.fault_code, mon_want.send_torque,
							mon_want.send_mc_disable, mon_want.do_calibration,
							mon_want.run_traction, mon_want.clear_discrepancy_timer,
							mon_got.mode, mon_got.fault_code, mon_got.send_torque,
							mon_got.send_mc_disable, mon_got.do_calibration,
							mon_got.run_traction, mon_got.clear_discrepancy_timer);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		plan = '{
			'{evl(3'b000, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b1,
				mk_res(MODE_NUM_LV, FLT_NONE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0)},
			'{{ACT_TICK, 41'd0}, 1'b1,
				mk_res(MODE_NUM_LV, FLT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
			// hv requested before calibration
			'{evl(SW_HV, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1,
				mk_res(MODE_NUM_FAULT, FLT_UNCAL, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0)},
			'{evl(3'b000, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{evl(SW_HV, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{{ACT_TICK, 41'd0}, 1'b0, '0},
			'{evl(SW_HV | SW_DR, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b1,
				mk_res(MODE_NUM_FAULT, FLT_DRIVE_LV, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)},
			'{evl(3'b000, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{evl(SW_HV, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{evl(SW_HV, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{evl(SW_HV | SW_DR, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1), 1'b1,
				mk_res(MODE_NUM_FAULT, FLT_BRAKE_NP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)},
			'{evl(SW_HV, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1), 1'b0, '0},
			'{evl(SW_HV | SW_DR, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{evl(SW_TC | SW_HV | SW_DR, 16'd0, 1'b1, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{evl(SW_HV | SW_DR, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1), 1'b1,
				mk_res(MODE_NUM_FAULT, FLT_IMPLAUS, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)},
			'{evl(SW_HV | SW_DR, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{evl(SW_DR, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b1,
				mk_res(MODE_NUM_FAULT, FLT_HV_OFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)},
			'{evl(3'b000, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{{ACT_EVAL, SW_HV | SW_DR, LOOP_MASK, 8'h00, 1'b1, 16'd0, 1'b0, 1'b1, 1'b0,
				1'b1, 1'b1}, 1'b1,
				mk_res(MODE_NUM_FAULT, FLT_DISCREP, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)},
			'{evl(SW_HV, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{{ACT_EVAL, 3'b000, 8'h00, 8'h00, 1'b1, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
				1'b1, mk_res(MODE_NUM_FAULT, FLT_SHUTDOWN, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)},
			'{{ACT_EVAL, SW_HV, 8'hFF, 8'h00, 1'b1, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
				1'b0, '0},
			'{{ACT_EVAL, SW_HV, LOOP_MASK, 8'hFF, 1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1,
				1'b0}, 1'b1,
				mk_res(MODE_NUM_FAULT, FLT_BSPD, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)},
			'{evl(SW_HV, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
			'{{ACT_TICK, {41{1'b1}}}, 1'b1,
				mk_res(MODE_NUM_LV, FLT_BSPD, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)}
		};
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		foreach (plan[i])
			send(plan[i].it, plan[i].typed, plan[i].want);
		repeat (70) send(next_item(), 1'b0, '0);
		run_phase(16'd0, 16'd0, 8'd1, 10, 100);
		// long phase so the timer can run into saturation
		run_phase(16'hFFFF, 16'hFFFF, 8'd255, 300, 300);
		run_phase(16'($urandom), 16'($urandom_range(0, 2000)), 8'($urandom_range(1, 255)),
			40, 100);
		run_phase(16'd1000, 16'd300, 8'd20, 40, 100);
		drain();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0d expected results never arrived", pending_results.size());
			n_fail += pending_results.size();
		end
		$display("%0d transactions sent under %0d register settings, %0d results checked",
			n_sent, n_settings, n_checked);
		$display("%0d mismatches", n_fail);
		if (n_fail == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
